// File: design/dfpc_pkg.sv
// Shared types, constants and helpers for the dark/flat pixel calibration block.
// No dependencies; every other design file imports this package.
package dfpc_pkg;

  // Field widths
  localparam int unsigned SampleW      = 16;
  localparam int unsigned GainW        = 24;
  localparam int unsigned GainFracBits = 8;   // gain of 1.0 is 256
  localparam int unsigned ProdW        = SampleW + GainW;
  localparam int unsigned NumW         = ProdW - GainFracBits;
  localparam int unsigned DivStagesDef = 4;

  // APB register map, word index from paddr[4:2]
  localparam int unsigned AddrW = 5;
  localparam logic [2:0] RegDarkEn  = 3'd0;
  localparam logic [2:0] RegFlatEn  = 3'd1;
  localparam logic [2:0] RegWide    = 3'd2;
  localparam logic [2:0] RegThree   = 3'd3;
  localparam logic [2:0] RegGain    = 3'd4;
  localparam logic [GainW-1:0] GainReset = GainW'(256);

  // Per-sample operation chosen at the front of the pipe
  typedef enum logic [1:0] {
    OpPass = 2'd0,
    OpDark = 2'd1,
    OpFlat = 2'd2,
    OpZero = 2'd3
  } op_e;

  // Configuration registers
  typedef struct packed {
    logic             dark_en;
    logic             flat_en;
    logic             wide;
    logic             three;
    logic [GainW-1:0] gain;
  } cfg_t;

  // Sideband that rides along the divider
  typedef struct packed {
    op_e                op;
    logic               wide;
    logic [SampleW-1:0] direct;  // result for pass/dark/zero-flat
    logic               last;
  } side_t;

  // One restoring-division step
  typedef struct packed {
    logic               q;
    logic [SampleW-1:0] rem;
  } dstep_t;

  function automatic logic [SampleW-1:0] full_scale(input logic wide);
    return wide ? {SampleW{1'b1}} : SampleW'(8'hFF);
  endfunction

  function automatic dstep_t div_step(input logic [SampleW-1:0] rem,
                                      input logic               nbit,
                                      input logic [SampleW-1:0] divisor);
    logic [SampleW:0] r2;
    logic [SampleW:0] diff;
    dstep_t           res;
    r2   = {rem, nbit};
    diff = r2 - {1'b0, divisor};
    if (r2 >= {1'b0, divisor}) begin
      res.q   = 1'b1;
      res.rem = diff[SampleW-1:0];
    end else begin
      res.q   = 1'b0;
      res.rem = r2[SampleW-1:0];
    end
    return res;
  endfunction

endpackage

// File: design/dfpc_regs.sv
// APB configuration registers for the calibration block.
// Depends on dfpc_pkg for the register map and cfg_t.
module dfpc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dfpc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dfpc_pkg::cfg_t              cfg_o
);
  import dfpc_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_en <= 1'b0;
      cfg_q.flat_en <= 1'b0;
      cfg_q.wide    <= 1'b0;
      cfg_q.three   <= 1'b0;
      cfg_q.gain    <= GainReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegDarkEn: cfg_q.dark_en <= pwdata[0];
        RegFlatEn: cfg_q.flat_en <= pwdata[0];
        RegWide:   cfg_q.wide    <= pwdata[0];
        RegThree:  cfg_q.three   <= pwdata[0];
        RegGain:   cfg_q.gain    <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      RegDarkEn: prdata = {31'd0, cfg_q.dark_en};
      RegFlatEn: prdata = {31'd0, cfg_q.flat_en};
      RegWide:   prdata = {31'd0, cfg_q.wide};
      RegThree:  prdata = {31'd0, cfg_q.three};
      RegGain:   prdata = {{(32-GainW){1'b0}}, cfg_q.gain};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/dfpc_front.sv
// Front of the pipe: masking, mode decode, dark subtraction, then gain multiply.
// Two register stages; depends on dfpc_pkg.
module dfpc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dfpc_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dfpc_pkg::SampleW-1:0]    raw_i,
  input  logic [dfpc_pkg::SampleW-1:0]    dark_i,
  input  logic [dfpc_pkg::SampleW-1:0]    flat_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dfpc_pkg::NumW-1:0]       out_num_o,
  output logic [dfpc_pkg::SampleW-1:0]    out_flat_o,
  output dfpc_pkg::side_t                 out_side_o
);
  import dfpc_pkg::*;

  typedef struct packed {
    side_t              side;
    logic [SampleW-1:0] flat;
  } s1_t;

  typedef struct packed {
    side_t              side;
    logic [SampleW-1:0] flat;
    logic [NumW-1:0]    num;
  } s2_t;

  logic               s1_valid_q, s2_valid_q;
  logic               s1_rdy, s2_rdy;
  s1_t                s1_d, s1_q;
  s2_t                s2_d, s2_q;
  logic [SampleW-1:0] full, raw_m, dark_m, flat_m, diff;
  logic               dark_mode, flat_mode, bypass;
  logic [ProdW-1:0]   prod;

  // Stage 1: mask to sample width, clamp difference, pick operation
  always_comb begin
    full      = full_scale(cfg_i.wide);
    raw_m     = raw_i & full;
    dark_m    = dark_i & full;
    flat_m    = flat_i & full;
    diff      = (raw_m > dark_m) ? (raw_m - dark_m) : '0;
    dark_mode = cfg_i.dark_en & ~cfg_i.flat_en;
    flat_mode = cfg_i.flat_en & ~cfg_i.dark_en;
    bypass    = cfg_i.wide & cfg_i.three;

    s1_d.flat      = flat_m;
    s1_d.side.wide = cfg_i.wide;
    s1_d.side.last = last_i;
    if (bypass || !(dark_mode || flat_mode)) begin
      s1_d.side.op     = OpPass;
      s1_d.side.direct = raw_m;
    end else if (dark_mode) begin
      s1_d.side.op     = OpDark;
      s1_d.side.direct = diff;
    end else if (flat_m == '0) begin
      s1_d.side.op     = OpZero;
      s1_d.side.direct = full;
    end else begin
      s1_d.side.op     = OpFlat;
      s1_d.side.direct = diff;   // multiplicand for the flat path
    end
  end

  // Stage 2: difference times Q16.8 gain, fraction bits dropped
  always_comb begin
    prod        = ProdW'(s1_q.side.direct) * ProdW'(cfg_i.gain);
    s2_d.side   = s1_q.side;
    s2_d.flat   = s1_q.flat;
    s2_d.num    = prod[ProdW-1:GainFracBits];
  end

  // Ready chain: a stage loads when empty or when it drains
  assign s2_rdy     = ~s2_valid_q | out_ready_i;
  assign s1_rdy     = ~s1_valid_q | s2_rdy;
  assign in_ready_o = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_valid_q <= in_valid_i;
      if (s2_rdy) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) s1_q <= s1_d;
    if (s2_rdy && s1_valid_q) s2_q <= s2_d;
  end

  assign out_valid_o = s2_valid_q;
  assign out_num_o   = s2_q.num;
  assign out_flat_o  = s2_q.flat;
  assign out_side_o  = s2_q.side;

endmodule

// File: design/dfpc_div.sv
// Pipelined restoring divider: 32-bit numerator by 16-bit flat sample, 16-bit quotient.
// Flags quotients that do not fit 16 bits; depends on dfpc_pkg.
module dfpc_div #(
  parameter int unsigned DivStages = dfpc_pkg::DivStagesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dfpc_pkg::NumW-1:0]       in_num_i,
  input  logic [dfpc_pkg::SampleW-1:0]    in_flat_i,
  input  dfpc_pkg::side_t                 in_side_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dfpc_pkg::SampleW-1:0]    out_quo_o,
  output logic                            out_ovf_o,
  output dfpc_pkg::side_t                 out_side_o
);
  import dfpc_pkg::*;

  localparam int unsigned Steps = SampleW / DivStages;

  typedef struct packed {
    logic [SampleW-1:0] rem;
    logic [SampleW-1:0] num;   // numerator bits still to bring down, MSB first
    logic [SampleW-1:0] quo;
    logic [SampleW-1:0] flat;
    logic               ovf;
    side_t              side;
  } dstage_t;

  dstage_t              head;
  dstage_t              src     [DivStages];
  dstage_t              stage_d [DivStages];
  dstage_t              stage_q [DivStages];
  logic [DivStages-1:0] valid_q;
  logic [DivStages-1:0] vin;
  logic [DivStages:0]   rdy;

  // Upper half is the starting remainder; quotient overflows 16 bits
  // exactly when it is not below the divisor
  always_comb begin
    head.rem  = in_num_i[NumW-1:SampleW];
    head.num  = in_num_i[SampleW-1:0];
    head.quo  = '0;
    head.flat = in_flat_i;
    head.ovf  = (in_num_i[NumW-1:SampleW] >= in_flat_i);
    head.side = in_side_i;
  end

  assign rdy[DivStages] = out_ready_i;

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src[k] = head;
      assign vin[k] = in_valid_i;
    end else begin : g_next
      assign src[k] = stage_q[k-1];
      assign vin[k] = valid_q[k-1];
    end

    // SampleW / DivStages quotient bits per stage
    always_comb begin
      dstage_t cur;
      dstep_t  st;
      cur = src[k];
      for (int j = 0; j < Steps; j++) begin
        st      = div_step(cur.rem, cur.num[SampleW-1], cur.flat);
        cur.rem = st.rem;
        cur.num = {cur.num[SampleW-2:0], 1'b0};
        cur.quo = {cur.quo[SampleW-2:0], st.q};
      end
      stage_d[k] = cur;
    end

    assign rdy[k] = ~valid_q[k] | rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= vin[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vin[k]) stage_q[k] <= stage_d[k];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[DivStages-1];
  assign out_quo_o   = stage_q[DivStages-1].quo;
  assign out_ovf_o   = stage_q[DivStages-1].ovf;
  assign out_side_o  = stage_q[DivStages-1].side;

endmodule

// File: design/dark_flat_pixel_calibration.sv
// Top level of the dark/flat pixel calibration block: config port, pipe, output stage.
// Depends on dfpc_pkg, dfpc_regs, dfpc_front and dfpc_div.
//
// Usage:
//   Input stream s_axis_*: tdata carries raw, dark and flat samples (16 bits
//   each), tlast marks the last sample of a frame. Output stream m_axis_*:
//   tdata is the corrected sample, tuser flags a zero flat sample (output
//   forced to full scale), tlast copies the input tlast.
//   Configuration goes through the APB port (dark_enable, flat_enable,
//   wide_samples, three_channel, flat_gain at byte addresses 0,4,8,12,16);
//   write it only while the stream is idle.
//   Throughput: one sample per clock while m_axis_tready stays high. Each
//   beat passes through the front stages (mask/subtract, gain multiply),
//   the divider stages that resolve 16/DivStages quotient bits each, and
//   the output register.
//   Reset clears all valid bits and sets the registers to their defaults
//   (pass-through, gain 1.0). When the receiver stalls, the output beat
//   holds and empty stages ahead of it keep filling; s_axis_tready drops
//   only once every stage holds a beat.
module dark_flat_pixel_calibration #(
  parameter int unsigned DivStages = dfpc_pkg::DivStagesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dfpc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,   // raw[15:0], dark[31:16], flat[47:32]
  input  logic                        s_axis_tlast,   // frame_end
  // Output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,   // corrected_sample[15:0]
  output logic                        m_axis_tuser,   // flat_zero
  output logic                        m_axis_tlast    // frame_done
);
  import dfpc_pkg::*;

  cfg_t               cfg;
  logic               fr_valid, fr_ready;
  logic [NumW-1:0]    fr_num;
  logic [SampleW-1:0] fr_flat;
  side_t              fr_side;
  logic               dv_valid, dv_ready;
  logic [SampleW-1:0] dv_quo;
  logic               dv_ovf;
  side_t              dv_side;

  logic               out_valid_q;
  logic [SampleW-1:0] out_data_q, out_data_d;
  logic               out_zero_q, out_zero_d;
  logic               out_last_q;
  logic               out_rdy;
  logic [SampleW-1:0] sat16;

  dfpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dfpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .raw_i       (s_axis_tdata[15:0]),
    .dark_i      (s_axis_tdata[31:16]),
    .flat_i      (s_axis_tdata[47:32]),
    .last_i      (s_axis_tlast),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_num_o   (fr_num),
    .out_flat_o  (fr_flat),
    .out_side_o  (fr_side)
  );

  dfpc_div #(
    .DivStages (DivStages)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_num_i    (fr_num),
    .in_flat_i   (fr_flat),
    .in_side_i   (fr_side),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .out_quo_o   (dv_quo),
    .out_ovf_o   (dv_ovf),
    .out_side_o  (dv_side)
  );

  // Saturate the quotient and pick the result for the operation
  always_comb begin
    sat16 = dv_ovf ? {SampleW{1'b1}} : dv_quo;
    if (!dv_side.wide && sat16 > full_scale(1'b0)) begin
      sat16 = full_scale(1'b0);
    end
    case (dv_side.op)
      OpFlat:  out_data_d = sat16;
      OpPass,
      OpDark,
      OpZero:  out_data_d = dv_side.direct;
      default: out_data_d = dv_side.direct;
    endcase
    out_zero_d = (dv_side.op == OpZero);
  end

  // Output register
  assign out_rdy  = ~out_valid_q | m_axis_tready;
  assign dv_ready = out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && dv_valid) begin
      out_data_q <= out_data_d;
      out_zero_q <= out_zero_d;
      out_last_q <= dv_side.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_zero_q;
  assign m_axis_tlast  = out_last_q;

  // A zero-flat beat always carries full scale
  a_zero_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == full_scale(cfg.wide))
    else $error("zero-flat beat not at full scale");

  // Narrow samples never carry an upper byte
  a_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !cfg.wide |-> m_axis_tdata[15:8] == 8'd0)
    else $error("8-bit result exceeds 255");

  // Zero-flat flag only in flat mode
  a_flag_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> cfg.flat_en && !cfg.dark_en)
    else $error("zero-flat flag outside flat mode");

  // A held output beat survives a stall
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_data_q))
    else $error("output beat lost during stall");

endmodule
